@@ design/bpct_pkg.sv @@
// shared types, widths and constants of the bandwidth pipe completion timer
`default_nettype none

package bpct_pkg;

   // field widths
   localparam int NOW_WIDTH       = 64;
   localparam int LEN_WIDTH       = 32;
   localparam int BW_WIDTH        = 40;
   localparam int NS_WIDTH        = 30;
   localparam int PROD_WIDTH      = LEN_WIDTH + NS_WIDTH;
   localparam int DIV_WIDTH       = 64;
   localparam int TOTAL_WIDTH     = 64;
   localparam int CSR_INDEX_WIDTH = 4;

   // nanoseconds per second and bandwidth after reset
   localparam logic [NS_WIDTH-1:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [BW_WIDTH-1:0] BW_RESET   = 40'd1000000000;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // request opcodes
   typedef enum logic [1:0] {
      OP_WRITE_START = 2'd0,
      OP_WRITE_DONE  = 2'd1,
      OP_READ_START  = 2'd2,
      OP_READ_DONE   = 2'd3
   } bpct_op_type;

   // result actions
   localparam logic ACT_SCHEDULE = 1'b0;
   localparam logic ACT_REPLY    = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_BW = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_BW  = 4'd1;

   // request transaction
   typedef struct packed {
      bpct_op_type          op;
      logic [NOW_WIDTH-1:0] now_ns;
      logic [LEN_WIDTH-1:0] length;
   } bpct_req_type;

   // result transaction
   typedef struct packed {
      logic                   action;
      bpct_op_type            next_op;
      logic [NOW_WIDTH-1:0]   delay_ns;
      logic [LEN_WIDTH-1:0]   reply_length;
      logic [TOTAL_WIDTH-1:0] writes_total;
      logic [TOTAL_WIDTH-1:0] reads_total;
      logic [TOTAL_WIDTH-1:0] bytes_written_total;
      logic [TOTAL_WIDTH-1:0] bytes_read_total;
      logic [TOTAL_WIDTH-1:0] write_delay_total;
      logic [TOTAL_WIDTH-1:0] read_delay_total;
   } bpct_rsp_type;

   // classified request held in the queue
   typedef struct packed {
      bpct_op_type           op;
      logic                  is_start;
      logic                  is_write;
      logic [NOW_WIDTH-1:0]  now_ns;
      logic [LEN_WIDTH-1:0]  length;
      logic [PROD_WIDTH-1:0] product;
   } bpct_item_type;

   // divider start request
   typedef struct packed {
      logic                 start;
      logic [DIV_WIDTH-1:0] dividend;
      logic [BW_WIDTH-1:0]  divisor;
   } bpct_div_req_type;

   // divider completion
   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } bpct_div_rsp_type;

endpackage

`default_nettype wire

@@ design/bpct_front.sv @@
// front end: accepts and classifies requests, scales length, queues them for the back end
`default_nettype none

module bpct_front #(
   parameter int QUEUE_DEPTH = bpct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire bpct_pkg::bpct_req_type  req_item,
   output logic                         q_valid,
   output bpct_pkg::bpct_item_type      q_head,
   input  wire logic                    q_pop
);
   import bpct_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   bpct_item_type          queue_mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   bpct_item_type          entry_in;
   logic                   push_ok;
   logic                   pop_ok;

   // classify and scale the incoming request
   always_comb begin
      entry_in.op       = req_item.op;
      entry_in.is_start = (req_item.op == OP_WRITE_START) || (req_item.op == OP_READ_START);
      entry_in.is_write = (req_item.op == OP_WRITE_START) || (req_item.op == OP_WRITE_DONE);
      entry_in.now_ns   = req_item.now_ns;
      entry_in.length   = req_item.length;
      entry_in.product  = PROD_WIDTH'(req_item.length) * PROD_WIDTH'(NS_PER_SEC);
   end

   // queue status
   assign req_full = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;
   assign q_head   = queue_mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   // queue control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ design/bpct_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module bpct_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bpct_pkg::bpct_div_req_type  div_req,
   output bpct_pkg::bpct_div_rsp_type       div_rsp
);
   import bpct_pkg::*;

   localparam int STEP_WIDTH = $clog2(DIV_WIDTH);

   logic                   busy_ff;
   logic                   done_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [DIV_WIDTH-1:0]   quot_ff;
   logic [BW_WIDTH-1:0]    rem_ff;
   logic [BW_WIDTH-1:0]    divisor_ff;
   logic [BW_WIDTH:0]      rem_shift;
   logic [BW_WIDTH:0]      rem_diff;
   logic                   fits;

   // one restoring step; a zero divisor always fits and yields all ones
   assign rem_shift = {rem_ff, quot_ff[DIV_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign fits      = (rem_shift >= {1'b0, divisor_ff});

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   // iteration control and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_WIDTH'(DIV_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quot_ff    <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DIV_WIDTH-2:0], fits};
         rem_ff  <= fits ? rem_diff[BW_WIDTH-1:0] : rem_shift[BW_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

@@ design/bpct_back.sv @@
// back end: pipe timing, running totals, bandwidth registers and result register
`default_nettype none

module bpct_back (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [bpct_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  wire logic [bpct_pkg::BW_WIDTH-1:0]             csr_data,
   input  wire logic                                      q_valid,
   input  wire bpct_pkg::bpct_item_type                   q_head,
   output logic                                           q_pop,
   output bpct_pkg::bpct_div_req_type                     div_req,
   input  wire bpct_pkg::bpct_div_rsp_type                div_rsp,
   output logic                                           rsp_empty,
   input  wire logic                                      rsp_pop,
   output bpct_pkg::bpct_rsp_type                         rsp_item
);
   import bpct_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type               state_ff;
   logic                    rsp_valid_ff;
   bpct_rsp_type            rsp_ff;

   logic [BW_WIDTH-1:0]     write_bw_ff;
   logic [BW_WIDTH-1:0]     read_bw_ff;

   logic [NOW_WIDTH-1:0]    write_free_ff, write_free_in;
   logic [NOW_WIDTH-1:0]    read_free_ff, read_free_in;
   logic [TOTAL_WIDTH-1:0]  write_count_ff, write_count_in;
   logic [TOTAL_WIDTH-1:0]  read_count_ff, read_count_in;
   logic [TOTAL_WIDTH-1:0]  written_bytes_ff, written_bytes_in;
   logic [TOTAL_WIDTH-1:0]  read_bytes_ff, read_bytes_in;
   logic [TOTAL_WIDTH-1:0]  write_delay_ff, write_delay_in;
   logic [TOTAL_WIDTH-1:0]  read_delay_ff, read_delay_in;

   bpct_op_type             op_ff;
   logic [NOW_WIDTH-1:0]    now_ff;
   logic [LEN_WIDTH-1:0]    length_ff;
   logic [NOW_WIDTH-1:0]    backlog_ff, backlog_in;
   logic [NOW_WIDTH-1:0]    delay_ff, delay_in;

   logic [NOW_WIDTH-1:0]    head_free;
   logic [NOW_WIDTH:0]      delay_sum;
   logic [NOW_WIDTH:0]      free_sum;
   logic [NOW_WIDTH-1:0]    free_sat;
   logic                    action_in;
   bpct_op_type             next_op_in;
   logic [LEN_WIDTH-1:0]    reply_in;
   logic                    out_free;
   logic                    dispatch;
   logic                    load_rsp;

   assign csr_ready = 1'b1;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign load_rsp  = (state_ff == ST_FIN) && out_free;

   // dispatch from the queue and start the divider for start requests
   assign dispatch         = (state_ff == ST_IDLE) && q_valid;
   assign q_pop            = dispatch;
   assign div_req.start    = dispatch && q_head.is_start;
   assign div_req.dividend = DIV_WIDTH'(q_head.product);
   assign div_req.divisor  = q_head.is_write ? write_bw_ff : read_bw_ff;

   // backlog of the addressed pipe
   assign head_free  = q_head.is_write ? write_free_ff : read_free_ff;
   assign backlog_in = (head_free > q_head.now_ns) ? head_free - q_head.now_ns : '0;

   // saturating delay and free time
   assign delay_sum = {1'b0, backlog_ff} + {1'b0, div_rsp.quotient};
   assign delay_in  = delay_sum[NOW_WIDTH] ? '1 : delay_sum[NOW_WIDTH-1:0];
   assign free_sum  = {1'b0, now_ff} + {1'b0, delay_ff};
   assign free_sat  = free_sum[NOW_WIDTH] ? '1 : free_sum[NOW_WIDTH-1:0];

   // state and totals after the current request
   always_comb begin
      write_free_in    = write_free_ff;
      read_free_in     = read_free_ff;
      write_count_in   = write_count_ff;
      read_count_in    = read_count_ff;
      written_bytes_in = written_bytes_ff;
      read_bytes_in    = read_bytes_ff;
      write_delay_in   = write_delay_ff;
      read_delay_in    = read_delay_ff;
      action_in        = ACT_SCHEDULE;
      next_op_in       = OP_WRITE_DONE;
      reply_in         = length_ff;
      case (op_ff)
         OP_WRITE_START: begin
            write_free_in    = free_sat;
            write_count_in   = write_count_ff + 1'b1;
            written_bytes_in = written_bytes_ff + TOTAL_WIDTH'(length_ff);
            write_delay_in   = write_delay_ff + delay_ff;
         end
         OP_WRITE_DONE: begin
            action_in = ACT_REPLY;
            reply_in  = '0;
         end
         OP_READ_START: begin
            read_free_in  = free_sat;
            read_delay_in = read_delay_ff + delay_ff;
            next_op_in    = OP_READ_DONE;
         end
         OP_READ_DONE: begin
            read_count_in = read_count_ff + 1'b1;
            read_bytes_in = read_bytes_ff + TOTAL_WIDTH'(length_ff);
            action_in     = ACT_REPLY;
            next_op_in    = OP_READ_DONE;
         end
         default: begin
         end
      endcase
   end

   // sequencer, architectural state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         write_bw_ff      <= BW_RESET;
         read_bw_ff       <= BW_RESET;
         write_free_ff    <= '0;
         read_free_ff     <= '0;
         write_count_ff   <= '0;
         read_count_ff    <= '0;
         written_bytes_ff <= '0;
         read_bytes_ff    <= '0;
         write_delay_ff   <= '0;
         read_delay_ff    <= '0;
      end else begin
         // register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_WRITE_BW: write_bw_ff <= csr_data;
               CSR_READ_BW:  read_bw_ff  <= csr_data;
               default: begin
               end
            endcase
         end

         // result held until taken, refilled when the current request finishes
         rsp_valid_ff <= load_rsp || (rsp_valid_ff && !rsp_pop);

         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  op_ff      <= q_head.op;
                  now_ff     <= q_head.now_ns;
                  length_ff  <= q_head.length;
                  backlog_ff <= backlog_in;
                  delay_ff   <= '0;
                  state_ff   <= q_head.is_start ? ST_DIV : ST_FIN;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  delay_ff <= delay_in;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  write_free_ff          <= write_free_in;
                  read_free_ff           <= read_free_in;
                  write_count_ff         <= write_count_in;
                  read_count_ff          <= read_count_in;
                  written_bytes_ff       <= written_bytes_in;
                  read_bytes_ff          <= read_bytes_in;
                  write_delay_ff         <= write_delay_in;
                  read_delay_ff          <= read_delay_in;
                  rsp_ff.action              <= action_in;
                  rsp_ff.next_op             <= next_op_in;
                  rsp_ff.delay_ns            <= delay_ff;
                  rsp_ff.reply_length        <= reply_in;
                  rsp_ff.writes_total        <= write_count_in;
                  rsp_ff.reads_total         <= read_count_in;
                  rsp_ff.bytes_written_total <= written_bytes_in;
                  rsp_ff.bytes_read_total    <= read_bytes_in;
                  rsp_ff.write_delay_total   <= write_delay_in;
                  rsp_ff.read_delay_total    <= read_delay_in;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ design/bandwidth_pipe_completion_timer.sv @@
// Bandwidth pipe completion timer: two independent pipes (write and read) each
// turn a start request into a completion delay, backlog of the pipe plus
// length * 1e9 / bandwidth nanoseconds, saturating at all ones, and advance the
// pipe's free time to now plus that delay; done requests return a reply, read
// dones update the read totals. Requests enter a small queue (QUEUE_DEPTH entries)
// that takes new transactions while the back end works and while a result waits
// in the output register. A start request passes through the back end in order:
// dispatch, the shared restoring divider (one quotient bit per cycle), adding the
// backlog, and updating the pipe and totals once the output register is free.
// A done request skips the divider. Bandwidth registers are written via the csr
// port (index 0 write bandwidth, index 1 read bandwidth, other indexes ignored);
// csr_ready is always high. A bandwidth of zero yields a transfer time of all ones.
`default_nettype none

module bandwidth_pipe_completion_timer #(
   parameter int QUEUE_DEPTH = bpct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire bpct_pkg::bpct_req_type                 req_item,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output bpct_pkg::bpct_rsp_type                      rsp_item,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [bpct_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [bpct_pkg::BW_WIDTH-1:0]          csr_data
);
   import bpct_pkg::*;

   logic              q_valid;
   logic              q_pop;
   bpct_item_type     q_head;
   bpct_div_req_type  div_req;
   bpct_div_rsp_type  div_rsp;

   // request intake and queue
   bpct_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   // transfer time divider
   bpct_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // pipe timing and totals
   bpct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

@@ tb/bandwidth_pipe_completion_timer_tb.sv @@
// self-checking testbench for the bandwidth pipe completion timer
module bandwidth_pipe_completion_timer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpct_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 168;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 80;
   localparam int MAX_REPORTS     = 200;

   // one line of the directed stimulus
   typedef struct {
      logic                       is_csr;
      logic [CSR_INDEX_WIDTH-1:0] csr_idx;
      logic [BW_WIDTH-1:0]        csr_val;
      bpct_req_type               req;
      logic                       typed;
      bpct_rsp_type               want;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   bpct_req_type               req_item = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   bpct_rsp_type               rsp_item;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [BW_WIDTH-1:0]        csr_data = '0;

   // predicted device state
   logic [BW_WIDTH-1:0]    write_bw_setting = BW_RESET;
   logic [BW_WIDTH-1:0]    read_bw_setting  = BW_RESET;
   logic [NOW_WIDTH-1:0]   write_pipe_free  = '0;
   logic [NOW_WIDTH-1:0]   read_pipe_free   = '0;
   logic [TOTAL_WIDTH-1:0] write_starts     = '0;
   logic [TOTAL_WIDTH-1:0] read_dones       = '0;
   logic [TOTAL_WIDTH-1:0] written_sum      = '0;
   logic [TOTAL_WIDTH-1:0] read_sum         = '0;
   logic [TOTAL_WIDTH-1:0] write_delay_acc  = '0;
   logic [TOTAL_WIDTH-1:0] read_delay_acc   = '0;

   bpct_rsp_type         expected_completions[$];
   stim_row_type         opening_rows[$];
   stim_row_type         closing_rows[$];
   logic [NOW_WIDTH-1:0] time_base = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_left      = 0;
   int error_count        = 0;
   int results_checked    = 0;
   int register_writes    = 0;
   int cycle_count        = 0;
   int op_count[4]        = '{0, 0, 0, 0};

   bandwidth_pipe_completion_timer dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_completions.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // addition clamped at all ones
   function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // backlog plus transfer time; moves the pipe's free time
   function automatic logic [63:0] pipe_delay(inout logic [63:0] free_time,
                                              input logic [BW_WIDTH-1:0] bw,
                                              input logic [63:0] now,
                                              input logic [31:0] len);
      logic [63:0] backlog;
      logic [63:0] xfer;
      logic [63:0] delay;
      backlog   = (free_time > now) ? free_time - now : 64'd0;
      xfer      = (bw == '0) ? '1 : (64'(len) * 64'd1000000000) / 64'(bw);
      delay     = add_clamped(backlog, xfer);
      free_time = add_clamped(now, delay);
      return delay;
   endfunction

   // expected result of one request, updating the predicted state
   function automatic bpct_rsp_type predict_completion(input bpct_req_type r);
      bpct_rsp_type p;
      p = '0;
      p.reply_length = r.length;
      case (r.op)
         OP_WRITE_START: begin
            p.delay_ns = pipe_delay(write_pipe_free, write_bw_setting, r.now_ns, r.length);
            write_delay_acc += p.delay_ns;
            written_sum     += 64'(r.length);
            write_starts    += 64'd1;
            p.action  = ACT_SCHEDULE;
            p.next_op = OP_WRITE_DONE;
         end
         OP_WRITE_DONE: begin
            p.action       = ACT_REPLY;
            p.next_op      = OP_WRITE_DONE;
            p.reply_length = '0;
         end
         OP_READ_START: begin
            p.delay_ns = pipe_delay(read_pipe_free, read_bw_setting, r.now_ns, r.length);
            read_delay_acc += p.delay_ns;
            p.action  = ACT_SCHEDULE;
            p.next_op = OP_READ_DONE;
         end
         default: begin
            read_sum   += 64'(r.length);
            read_dones += 64'd1;
            p.action  = ACT_REPLY;
            p.next_op = OP_READ_DONE;
         end
      endcase
      p.writes_total        = write_starts;
      p.reads_total         = read_dones;
      p.bytes_written_total = written_sum;
      p.bytes_read_total    = read_sum;
      p.write_delay_total   = write_delay_acc;
      p.read_delay_total    = read_delay_acc;
      return p;
   endfunction

   // table row builders
   function automatic stim_row_type item_row(input bpct_op_type op, input logic [63:0] now,
                                             input logic [31:0] len);
      stim_row_type row;
      row         = '{default: '0};
      row.req     = '{op: op, now_ns: now, length: len};
      return row;
   endfunction

   function automatic stim_row_type typed_row(input bpct_op_type op, input logic [63:0] now,
                                              input logic [31:0] len,
                                              input bpct_rsp_type want);
      stim_row_type row;
      row       = item_row(op, now, len);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                            input logic [BW_WIDTH-1:0] val);
      stim_row_type row;
      row         = '{default: '0};
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   // random bandwidth: reset value, a moderate rate, or any nonzero 40-bit value
   function automatic logic [BW_WIDTH-1:0] pick_bandwidth();
      logic [BW_WIDTH-1:0] v;
      case ($urandom_range(3))
         0:       v = BW_RESET;
         1:       v = 40'($urandom_range(32'd4000000000, 32'd1000000));
         default: v = 40'({8'($urandom_range(255)), $urandom});
      endcase
      return (v == '0) ? 40'd1 : v;
   endfunction

   // random request; time mostly runs forward, wild mode uses any 64-bit time
   function automatic bpct_req_type random_request(input bit wild);
      bpct_req_type r;
      r.op = bpct_op_type'($urandom_range(3));
      if (wild) begin
         r.now_ns = {$urandom, $urandom};
      end else begin
         if ($urandom_range(99) < 85)
            time_base += 64'($urandom_range(4000));
         else
            time_base += {29'd0, 3'($urandom_range(7)), $urandom};
         r.now_ns = time_base;
      end
      case ($urandom_range(9))
         0:       r.length = '0;
         1:       r.length = '1;
         2, 3:    r.length = $urandom;
         default: r.length = 32'($urandom_range(4095));
      endcase
      return r;
   endfunction

   // offer one request transaction, with random idle cycles first
   task automatic send_request(input bpct_req_type r, input logic typed,
                               input bpct_rsp_type want);
      bpct_rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= r;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      predicted = predict_completion(r);
      expected_completions.push_back(typed ? want : predicted);
      op_count[r.op]++;
   endtask

   // stop offering and let every outstanding result drain
   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_completions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write transaction; valid is left high for the caller to drop
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [BW_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == CSR_WRITE_BW)
         write_bw_setting = val;
      else if (idx == CSR_READ_BW)
         read_bw_setting = val;
      register_writes++;
   endtask

   // walk a directed table
   task automatic run_table(input stim_row_type rows[$]);
      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            if (!csr_valid) wait_idle();
            write_register(rows[i].csr_idx, rows[i].csr_val);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            send_request(rows[i].req, rows[i].typed, rows[i].want);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         // keep the log bounded when the design is badly broken
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // result side: check each popped transaction, then decide the next pop
   initial begin
      bpct_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (expected_completions.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got %0h", $time, rsp_item);
            end else begin
               want = expected_completions.pop_front();
               check_field("action", 64'(want.action), 64'(rsp_item.action));
               check_field("next_op", 64'(want.next_op), 64'(rsp_item.next_op));
               check_field("delay_ns", want.delay_ns, rsp_item.delay_ns);
               check_field("reply_length", 64'(want.reply_length),
                           64'(rsp_item.reply_length));
               check_field("writes_total", want.writes_total, rsp_item.writes_total);
               check_field("reads_total", want.reads_total, rsp_item.reads_total);
               check_field("bytes_written_total", want.bytes_written_total,
                           rsp_item.bytes_written_total);
               check_field("bytes_read_total", want.bytes_read_total,
                           rsp_item.bytes_read_total);
               check_field("write_delay_total", want.write_delay_total,
                           rsp_item.write_delay_total);
               check_field("read_delay_total", want.read_delay_total,
                           rsp_item.read_delay_total);
               results_checked++;
            end
         end
         // long hold-off fills the block and backs up the request side
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [BW_WIDTH-1:0] new_write_bw;
      logic [BW_WIDTH-1:0] new_read_bw;

      // opening rows: state after reset, field extremes, every operation
      opening_rows.push_back(typed_row(OP_WRITE_DONE, 64'd0, 32'hFFFF_FFFF,
         '{action: ACT_REPLY, next_op: OP_WRITE_DONE, default: '0}));
      opening_rows.push_back(typed_row(OP_READ_DONE, 64'd0, 32'hFFFF_FFFF,
         '{action: ACT_REPLY, next_op: OP_READ_DONE, reply_length: 32'hFFFF_FFFF,
           reads_total: 64'd1, bytes_read_total: 64'hFFFF_FFFF, default: '0}));
      opening_rows.push_back(typed_row(OP_WRITE_START, 64'd0, 32'd1000,
         '{action: ACT_SCHEDULE, next_op: OP_WRITE_DONE, delay_ns: 64'd1000,
           reply_length: 32'd1000, writes_total: 64'd1, reads_total: 64'd1,
           bytes_written_total: 64'd1000, bytes_read_total: 64'hFFFF_FFFF,
           write_delay_total: 64'd1000, default: '0}));
      opening_rows.push_back(typed_row(OP_READ_START, 64'd0, 32'd0,
         '{action: ACT_SCHEDULE, next_op: OP_READ_DONE, writes_total: 64'd1,
           reads_total: 64'd1, bytes_written_total: 64'd1000,
           bytes_read_total: 64'hFFFF_FFFF, write_delay_total: 64'd1000, default: '0}));
      opening_rows.push_back(item_row(OP_WRITE_START, 64'd500, 32'd2000));
      opening_rows.push_back(item_row(OP_READ_START, 64'd10, 32'hFFFF_FFFF));
      opening_rows.push_back(item_row(OP_READ_DONE, 64'd20, 32'd0));
      opening_rows.push_back(item_row(OP_WRITE_DONE, 64'd30, 32'h5555_AAAA));
      // bandwidth extremes
      opening_rows.push_back(csr_row(CSR_WRITE_BW, '1));
      opening_rows.push_back(csr_row(CSR_READ_BW, 40'd1));
      opening_rows.push_back(item_row(OP_WRITE_START, 64'd40, 32'hFFFF_FFFF));
      opening_rows.push_back(item_row(OP_READ_START, 64'd50, 32'd3));
      opening_rows.push_back(item_row(OP_READ_START, 64'd60, 32'd0));
      opening_rows.push_back(item_row(OP_WRITE_DONE, 64'd70, 32'hFFFF_FFFF));
      // indexes past the register list are ignored
      opening_rows.push_back(csr_row(CSR_INDEX_WIDTH'(2), 40'd12345));
      opening_rows.push_back(csr_row('1, '1));
      opening_rows.push_back(item_row(OP_WRITE_START, 64'd80, 32'd1));
      opening_rows.push_back(item_row(OP_READ_DONE, 64'd90, 32'hFFFF_FFFF));

      // closing rows: saturation cases, run last since a saturated pipe stays busy
      closing_rows.push_back(csr_row(CSR_WRITE_BW, '0));
      closing_rows.push_back(csr_row(CSR_READ_BW, BW_RESET));
      // zero bandwidth gives an all-ones transfer time
      closing_rows.push_back(item_row(OP_WRITE_START, 64'd0, 32'd1));
      // backlog plus transfer time clamps
      closing_rows.push_back(item_row(OP_WRITE_START, 64'd5, 32'd0));
      // now plus delay clamps the free time
      closing_rows.push_back(item_row(OP_READ_START, '1, 32'hFFFF_FFFF));
      closing_rows.push_back(item_row(OP_READ_START, '1, 32'd0));
      closing_rows.push_back(item_row(OP_READ_DONE, '1, 32'hFFFF_FFFF));
      closing_rows.push_back(item_row(OP_WRITE_DONE, '1, 32'd0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_table(opening_rows);
      if (csr_valid) csr_valid <= 1'b0;

      // random phases, each with its own bandwidths and idle pattern
      time_base = 64'd20000000000;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         new_write_bw = pick_bandwidth();
         new_read_bw  = pick_bandwidth();
         write_register(CSR_WRITE_BW, new_write_bw);
         write_register(CSR_READ_BW, new_read_bw);
         csr_valid <= 1'b0;
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
         endcase
         if (phase == 0) hold_off_left = HOLD_OFF_CYCLES;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request(phase == PHASES - 1), 1'b0, '0);
      end

      run_table(closing_rows);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d write starts, %0d write dones, %0d read starts, %0d read dones",
               op_count[OP_WRITE_START], op_count[OP_WRITE_DONE],
               op_count[OP_READ_START], op_count[OP_READ_DONE]);
      $display("%0d results checked, %0d register writes, %0d mismatches",
               results_checked, register_writes, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
